/* sv/bsa_pkg.sv */
// Package for the bitmap slot allocator: operation codes, word geometry,
// and the command and status structs between controller and datapath.
// No dependencies.
`default_nettype none
package bsa_pkg;

  localparam int POOL_SLOTS_DEF = 256;
  localparam int WORD_W         = 32;
  localparam int BIT_W          = 5;

  localparam logic [2:0] KIND_ALLOC     = 3'd0;
  localparam logic [2:0] KIND_FREE      = 3'd1;
  localparam logic [2:0] KIND_SET_MARK  = 3'd2;
  localparam logic [2:0] KIND_CLR_MARK  = 3'd3;
  localparam logic [2:0] KIND_CLR_MARKS = 3'd4;
  localparam logic [2:0] KIND_QUERY     = 3'd5;

  typedef struct packed {
    logic accept;
    logic scan_next;
    logic exec_wr;
    logic res_load;
    logic out_load;
    logic out_from_res;
    logic sweep_start;
    logic sweep_step;
    logic wipe_all;
    logic wipe_marks;
  } bsa_cmd_t;

  typedef struct packed {
    logic is_alloc;
    logic is_clear_all;
    logic has_free;
    logic last_word;
    logic out_space;
  } bsa_status_t;

endpackage
`default_nettype wire

/* sv/bitmap_slot_allocator_with_marks_unit.sv */
// Free, mark and query results load in ST_EXEC, or in ST_PUSH once out_tdata is free.
// Allocate scans 32-slot words up to one with a free slot, at most ceil(POOL_SLOTS/32).
// Clear all marks zeroes the mark words one word a cycle, from word 0 to the last.
// After reset both bitmaps are cleared one word a cycle, all ceil(POOL_SLOTS/32) words
// (8 at the default pool), with in_tready low; the used count resets to zero.
// Depends on bsa_pkg, bsa_ctrl and bsa_dp.
`default_nettype none
module bitmap_slot_allocator_with_marks_unit import bsa_pkg::*; #(
  parameter int POOL_SLOTS = POOL_SLOTS_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // slot[7:0]
  input  wire  [2:0]  in_tuser,   // kind[2:0]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [23:0] out_tdata   // status[0], result_slot[8:1], slot_allocated[9],
                                  // slot_marked[10], used_slots[19:11], zero[23:20]
);

  bsa_cmd_t    cmd;
  bsa_status_t st;

  bsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  bsa_dp #(
    .POOL_SLOTS (POOL_SLOTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .st         (st)
  );

endmodule
`default_nettype wire

/* sv/bsa_ctrl.sv */
// Controller state machine for the bitmap slot allocator.
// Depends on bsa_pkg; drives the datapath bsa_dp through bsa_cmd_t.
`default_nettype none
module bsa_ctrl import bsa_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  bsa_status_t st,
  output bsa_cmd_t    cmd
);

  localparam logic [2:0] ST_WIPE  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_EXEC  = 3'd2;
  localparam logic [2:0] ST_SWEEP = 3'd3;
  localparam logic [2:0] ST_PUSH  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_tready = 1'b0;
    case (state_r)
      ST_WIPE: begin
        cmd.wipe_all   = 1'b1;
        cmd.sweep_step = 1'b1;
        if (st.last_word) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
        if (in_tvalid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (st.is_alloc && !st.has_free && !st.last_word) begin
          cmd.scan_next = 1'b1;
        end else if (st.is_clear_all) begin
          cmd.res_load    = 1'b1;
          cmd.sweep_start = 1'b1;
          state_nxt       = ST_SWEEP;
        end else begin
          cmd.exec_wr = 1'b1;
          if (st.out_space) begin
            cmd.out_load = 1'b1;
            state_nxt    = ST_IDLE;
          end else begin
            cmd.res_load = 1'b1;
            state_nxt    = ST_PUSH;
          end
        end
      end
      ST_SWEEP: begin
        cmd.wipe_marks = 1'b1;
        cmd.sweep_step = 1'b1;
        if (st.last_word) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (st.out_space) begin
          cmd.out_load     = 1'b1;
          cmd.out_from_res = 1'b1;
          state_nxt        = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_WIPE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_WIPE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTH
  a_load_has_space: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> st.out_space)
    else $error("result loaded over an untaken result");
  a_scan_stays: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_next |=> state_r == ST_EXEC)
    else $error("allocate scan left before finishing");
`endif

endmodule
`default_nettype wire

/* sv/bsa_dp.sv */
// Datapath for the bitmap slot allocator: allocation and mark word memories,
// first-free search within a word, used-slot counter and output register.
// Depends on bsa_pkg; controlled by bsa_ctrl.
`default_nettype none
module bsa_dp import bsa_pkg::*; #(
  parameter int POOL_SLOTS = POOL_SLOTS_DEF
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire  [7:0]   in_tdata,
  input  wire  [2:0]   in_tuser,
  output logic         out_tvalid,
  input  wire          out_tready,
  output logic [23:0]  out_tdata,
  input  bsa_cmd_t     cmd,
  output bsa_status_t  st
);

  localparam int WORDS = (POOL_SLOTS + WORD_W - 1) / WORD_W;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int CW    = $clog2(POOL_SLOTS + 1);

  logic [WORD_W-1:0] alloc_mem [WORDS];
  logic [WORD_W-1:0] mark_mem  [WORDS];
  logic [WORD_W-1:0] rd_alloc_r;
  logic [WORD_W-1:0] rd_mark_r;

  logic [AW-1:0]     cur_r;
  logic [AW-1:0]     cur_nxt;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     start_addr;
  logic [2:0]        kind_r;
  logic [7:0]        slot_r;
  logic [CW-1:0]     used_r;
  logic [CW-1:0]     used_nxt;

  logic              in_ok;
  logic              slot_ok;
  logic [7:0]        in_word;
  logic [BIT_W-1:0]  bsel;
  logic [WORD_W-1:0] bmask;
  logic [WORD_W-1:0] span;
  logic [WORD_W-1:0] avail;
  logic [WORD_W-1:0] first;
  logic [BIT_W-1:0]  fbit;
  logic [AW+BIT_W-1:0] found_idx;
  logic              a_bit;
  logic              m_bit;

  logic              alloc_we;
  logic              mark_we;
  logic [WORD_W-1:0] alloc_wd;
  logic [WORD_W-1:0] mark_wd;

  logic [19:0]       res_c;
  logic [19:0]       res_r;
  logic [19:0]       out_r;
  logic              out_valid_r;
  logic              out_valid_nxt;

  assign in_ok      = 32'(in_tdata) < POOL_SLOTS;
  assign in_word    = in_tdata >> BIT_W;
  assign start_addr = (in_tuser == KIND_ALLOC || !in_ok) ? '0 : AW'(in_word);
  assign slot_ok    = 32'(slot_r) < POOL_SLOTS;
  assign bsel       = slot_r[BIT_W-1:0];
  assign bmask      = WORD_W'(1) << bsel;
  assign a_bit      = rd_alloc_r[bsel] & slot_ok;
  assign m_bit      = rd_mark_r[bsel] & slot_ok;

  always_comb begin
    logic [AW+BIT_W-1:0] g;
    g = '0;
    for (int b = 0; b < WORD_W; b++) begin
      g       = {cur_r, BIT_W'(b)};
      span[b] = 32'(g) < POOL_SLOTS;
    end
  end

  assign avail = ~rd_alloc_r & span;
  assign first = avail & (~avail + WORD_W'(1));

  always_comb begin
    fbit = '0;
    for (int b = 0; b < WORD_W; b++) begin
      if (first[b]) begin
        fbit = fbit | BIT_W'(b);
      end
    end
  end

  assign found_idx = {cur_r, fbit};

  assign st.is_alloc     = kind_r == KIND_ALLOC;
  assign st.is_clear_all = kind_r == KIND_CLR_MARKS;
  assign st.has_free     = |avail;
  assign st.last_word    = 32'(cur_r) == WORDS - 1;
  assign st.out_space    = !out_valid_r || out_tready;

  always_comb begin
    if (cmd.accept) begin
      rd_addr = start_addr;
    end else if (cmd.scan_next) begin
      rd_addr = cur_r + AW'(1);
    end else begin
      rd_addr = cur_r;
    end
    if (cmd.accept) begin
      cur_nxt = start_addr;
    end else if (cmd.scan_next || cmd.sweep_step) begin
      cur_nxt = cur_r + AW'(1);
    end else if (cmd.sweep_start) begin
      cur_nxt = '0;
    end else begin
      cur_nxt = cur_r;
    end
  end

  always_comb begin
    alloc_we = 1'b0;
    mark_we  = 1'b0;
    alloc_wd = '0;
    mark_wd  = '0;
    used_nxt = used_r;
    if (cmd.wipe_all) begin
      alloc_we = 1'b1;
      mark_we  = 1'b1;
    end else if (cmd.wipe_marks) begin
      mark_we = 1'b1;
    end else if (cmd.exec_wr) begin
      case (kind_r)
        KIND_ALLOC: begin
          alloc_we = st.has_free;
          alloc_wd = rd_alloc_r | first;
          if (st.has_free) begin
            used_nxt = used_r + CW'(1);
          end
        end
        KIND_FREE: begin
          alloc_we = slot_ok;
          alloc_wd = rd_alloc_r & ~bmask;
          if (a_bit) begin
            used_nxt = used_r - CW'(1);
          end
        end
        KIND_SET_MARK: begin
          mark_we = slot_ok;
          mark_wd = rd_mark_r | bmask;
        end
        KIND_CLR_MARK: begin
          mark_we = slot_ok;
          mark_wd = rd_mark_r & ~bmask;
        end
        default: begin
        end
      endcase
    end
  end

  // Result layout from bit 0: status, result_slot, slot_allocated,
  // slot_marked, used_slots.
  always_comb begin
    case (kind_r)
      KIND_ALLOC: begin
        if (st.has_free) begin
          res_c = {9'(used_nxt), rd_mark_r[fbit], 1'b1, 8'(found_idx), 1'b0};
        end else begin
          res_c = {9'(used_nxt), 1'b0, 1'b0, 8'd0, 1'b1};
        end
      end
      KIND_FREE:      res_c = {9'(used_nxt), m_bit, 1'b0, slot_r, 1'b0};
      KIND_SET_MARK:  res_c = {9'(used_nxt), slot_ok, a_bit, slot_r, 1'b0};
      KIND_CLR_MARK:  res_c = {9'(used_nxt), 1'b0, a_bit, slot_r, 1'b0};
      KIND_CLR_MARKS: res_c = {9'(used_nxt), 1'b0, a_bit, slot_r, 1'b0};
      default:        res_c = {9'(used_nxt), m_bit, a_bit, slot_r, 1'b0};
    endcase
  end

  always_ff @(posedge clk) begin
    rd_alloc_r <= alloc_mem[rd_addr];
    rd_mark_r  <= mark_mem[rd_addr];
    if (alloc_we) begin
      alloc_mem[cur_r] <= alloc_wd;
    end
    if (mark_we) begin
      mark_mem[cur_r] <= mark_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r <= in_tuser;
      slot_r <= in_tdata;
    end
    if (cmd.res_load) begin
      res_r <= res_c;
    end
    if (cmd.out_load) begin
      out_r <= cmd.out_from_res ? res_r : res_c;
    end
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r       <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_r       <= cur_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_r};

`ifndef SYNTH
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(used_r) <= POOL_SLOTS)
    else $error("used slot count exceeds pool");
  a_alloc_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec_wr && st.is_alloc && st.has_free) |=> used_r == $past(used_r) + CW'(1))
    else $error("allocation did not bump the used count");
  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r[0]) |-> (out_r[8:1] == 8'd0 && !out_r[9] && !out_r[10]))
    else $error("pool-full result carries slot data");
`endif

endmodule
`default_nettype wire
